>>> rtl/lppbp_pkg.sv
package lppbp_pkg;

   localparam int NUM_FRAMES_DEF = 32;
   localparam int TABLE_BITS_DEF = 10;
   localparam int PIN_BITS_DEF   = 8;

   localparam int CMD_W    = 2;
   localparam int TABLE_W  = 10;
   localparam int PAGE_W   = 32;
   localparam int FRAME_W  = 5;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 6;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

   typedef enum logic [CMD_W-1:0] {
      CMD_READ,
      CMD_UNPIN,
      CMD_DIRTY,
      CMD_CLOSE
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK,
      STAT_ALL_PINNED,
      STAT_TABLE_PINNED
   } status_type;

   typedef enum logic [2:0] {
      DOP_NONE,
      DOP_CLEAR,
      DOP_HIT,
      DOP_DIRTY,
      DOP_INSTALL,
      DOP_RELEASE,
      DOP_UNPIN
   } dir_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UNPIN,
      S_DSCAN,
      S_HSCAN,
      S_VSCAN,
      S_INSTALL,
      S_CSCAN
   } state_type;

endpackage

>>> rtl/lppbp_if.sv
interface lppbp_req_if;
   logic                               valid;
   logic                               ready;
   logic [lppbp_pkg::CMD_W-1:0]        command;
   logic [lppbp_pkg::TABLE_W-1:0]      table_num;
   logic [lppbp_pkg::PAGE_W-1:0]       page_number;
   logic [lppbp_pkg::FRAME_W-1:0]      frame_index;
   modport source (output valid, command, table_num, page_number, frame_index, input ready);
   modport sink   (input valid, command, table_num, page_number, frame_index, output ready);
endinterface

interface lppbp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lppbp_pkg::FRAME_W-1:0]      frame_index_res;
   logic                               hit;
   logic                               load_request;
   logic                               writeback;
   logic [lppbp_pkg::TABLE_W-1:0]      writeback_table;
   logic [lppbp_pkg::PAGE_W-1:0]       writeback_page;
   logic [lppbp_pkg::STATUS_W-1:0]     status;
   logic                               last;
   modport source (output valid, frame_index_res, hit, load_request, writeback,
                   writeback_table, writeback_page, status, last, input ready);
   modport sink   (input valid, frame_index_res, hit, load_request, writeback,
                   writeback_table, writeback_page, status, last, output ready);
endinterface

interface lppbp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [lppbp_pkg::CFG_W-1:0]        frames_in_use;
   modport source (output valid, frames_in_use, input ready);
   modport sink   (input valid, frames_in_use, output ready);
endinterface

>>> rtl/lppbp_dir.sv
module lppbp_dir #(
   parameter int NUM_FRAMES = lppbp_pkg::NUM_FRAMES_DEF,
   parameter int TABLE_BITS = lppbp_pkg::TABLE_BITS_DEF,
   parameter int PIN_BITS   = lppbp_pkg::PIN_BITS_DEF,
   localparam int FW = $clog2(NUM_FRAMES),
   localparam int CW = $clog2(NUM_FRAMES + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lppbp_pkg::dir_op_type             op,
   input  logic [CW-1:0]                     pos,
   input  logic [FW-1:0]                     fidx,
   input  logic [TABLE_BITS-1:0]             new_tbl,
   input  logic [lppbp_pkg::PAGE_W-1:0]      ins_page,
   output logic [FW-1:0]                     rd_frame,
   output logic [TABLE_BITS-1:0]             rd_tbl,
   output logic [lppbp_pkg::PAGE_W-1:0]      rd_page,
   output logic                              rd_pin_zero,
   output logic                              rd_dirty,
   output logic                              fidx_in_use,
   output logic [CW-1:0]                     used
);

   logic [FW-1:0]                ord_ff   [NUM_FRAMES];
   logic [FW-1:0]                ord_in   [NUM_FRAMES];
   logic [PIN_BITS-1:0]          pin_ff   [NUM_FRAMES];
   logic [PIN_BITS-1:0]          pin_in   [NUM_FRAMES];
   logic [NUM_FRAMES-1:0]        dirty_ff, dirty_in;
   logic [NUM_FRAMES-1:0]        inuse_ff, inuse_in;
   logic [CW-1:0]                used_ff, used_in;
   logic [TABLE_BITS-1:0]        ftbl_ff  [NUM_FRAMES];
   logic [lppbp_pkg::PAGE_W-1:0] fpage_ff [NUM_FRAMES];
   logic [FW-1:0]                sel;

   assign sel         = (pos < CW'(NUM_FRAMES)) ? ord_ff[pos[FW-1:0]] : '0;
   assign rd_frame    = sel;
   assign rd_tbl      = ftbl_ff[sel];
   assign rd_page     = fpage_ff[sel];
   assign rd_pin_zero = (pin_ff[sel] == '0);
   assign rd_dirty    = dirty_ff[sel];
   assign fidx_in_use = inuse_ff[fidx];
   assign used        = used_ff;

   always_comb begin
      ord_in   = ord_ff;
      pin_in   = pin_ff;
      dirty_in = dirty_ff;
      inuse_in = inuse_ff;
      used_in  = used_ff;
      unique case (op)
         lppbp_pkg::DOP_CLEAR: begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
               ord_in[i] = FW'(i);
               pin_in[i] = '0;
            end
            dirty_in = '0;
            inuse_in = '0;
            used_in  = '0;
         end
         lppbp_pkg::DOP_HIT, lppbp_pkg::DOP_DIRTY, lppbp_pkg::DOP_INSTALL: begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
               if (i == 0) begin
                  ord_in[i] = sel;
               end else if (CW'(i) <= pos) begin
                  ord_in[i] = ord_ff[i-1];
               end
            end
            if (op != lppbp_pkg::DOP_DIRTY && pin_ff[sel] != '1) begin
               pin_in[sel] = pin_ff[sel] + PIN_BITS'(1);
            end
            if (op == lppbp_pkg::DOP_DIRTY) begin
               dirty_in[sel] = 1'b1;
            end
            if (op == lppbp_pkg::DOP_INSTALL) begin
               dirty_in[sel] = 1'b0;
               inuse_in[sel] = 1'b1;
               used_in       = used_ff + CW'(1);
            end
         end
         lppbp_pkg::DOP_RELEASE: begin
            for (int i = 0; i < NUM_FRAMES - 1; i++) begin
               if (CW'(i) >= pos && CW'(i + 1) < used_ff) begin
                  ord_in[i] = ord_ff[i+1];
               end
            end
            for (int i = 0; i < NUM_FRAMES; i++) begin
               if (CW'(i) == used_ff - CW'(1)) begin
                  ord_in[i] = sel;
               end
            end
            inuse_in[sel] = 1'b0;
            dirty_in[sel] = 1'b0;
            used_in       = used_ff - CW'(1);
         end
         lppbp_pkg::DOP_UNPIN: begin
            if (pin_ff[fidx] != '0) begin
               pin_in[fidx] = pin_ff[fidx] - PIN_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FRAMES; i++) begin
            ord_ff[i] <= FW'(i);
            pin_ff[i] <= '0;
         end
         dirty_ff <= '0;
         inuse_ff <= '0;
         used_ff  <= '0;
      end else begin
         ord_ff   <= ord_in;
         pin_ff   <= pin_in;
         dirty_ff <= dirty_in;
         inuse_ff <= inuse_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op == lppbp_pkg::DOP_INSTALL) begin
         ftbl_ff[sel]  <= new_tbl;
         fpage_ff[sel] <= ins_page;
      end
   end

endmodule

>>> rtl/lppbp_seq.sv
module lppbp_seq #(
   parameter int NUM_FRAMES = lppbp_pkg::NUM_FRAMES_DEF,
   parameter int TABLE_BITS = lppbp_pkg::TABLE_BITS_DEF,
   localparam int FW = $clog2(NUM_FRAMES),
   localparam int CW = $clog2(NUM_FRAMES + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   lppbp_req_if.sink                         req,
   lppbp_rsp_if.source                       rsp,
   input  logic                              cfg_write,
   input  logic [CW-1:0]                     nf,
   output logic                              idle,
   output lppbp_pkg::dir_op_type             op,
   output logic [CW-1:0]                     pos,
   output logic [FW-1:0]                     q_fidx,
   output logic [TABLE_BITS-1:0]             q_tbl,
   output logic [lppbp_pkg::PAGE_W-1:0]      q_page,
   input  logic [FW-1:0]                     rd_frame,
   input  logic [TABLE_BITS-1:0]             rd_tbl,
   input  logic [lppbp_pkg::PAGE_W-1:0]      rd_page,
   input  logic                              rd_pin_zero,
   input  logic                              rd_dirty,
   input  logic                              fidx_in_use,
   input  logic [CW-1:0]                     used
);

   lppbp_pkg::state_type                state_ff, state_in;
   logic [CW-1:0]                       p_ff, p_in;
   lppbp_pkg::cmd_type                  cmd_ff;
   logic [TABLE_BITS-1:0]               tbl_ff;
   logic [lppbp_pkg::PAGE_W-1:0]        page_ff;
   logic [lppbp_pkg::FRAME_W-1:0]       fidx_ff;
   logic                                wb_ff;
   logic [TABLE_BITS-1:0]               wbt_ff;
   logic [lppbp_pkg::PAGE_W-1:0]        wbp_ff;

   logic                                rv_ff;
   logic [lppbp_pkg::FRAME_W-1:0]       r_frame_ff;
   logic                                r_hit_ff, r_load_ff, r_wb_ff, r_last_ff;
   logic [lppbp_pkg::TABLE_W-1:0]       r_wbt_ff;
   logic [lppbp_pkg::PAGE_W-1:0]        r_wbp_ff;
   logic [lppbp_pkg::STATUS_W-1:0]      r_status_ff;

   logic                                emit, e_hit, e_load, e_wb, e_last;
   logic [lppbp_pkg::FRAME_W-1:0]       e_frame;
   logic [TABLE_BITS-1:0]               e_wbt;
   logic [lppbp_pkg::PAGE_W-1:0]        e_wbp;
   lppbp_pkg::status_type               e_status;

   logic slot_free, req_acc, scan_end, fidx_ok, m_read, m_close, m_frame;

   assign slot_free = !rv_ff || rsp.ready;
   assign req_acc   = req.valid && req.ready;
   assign scan_end  = (p_ff >= used);
   assign fidx_ok   = (32'(fidx_ff) < 32'(nf));
   assign m_close   = (rd_tbl == tbl_ff);
   assign m_read    = m_close && (rd_page == page_ff);
   assign m_frame   = (32'(rd_frame) == 32'(fidx_ff));
   assign idle      = (state_ff == lppbp_pkg::S_IDLE);
   assign req.ready = idle && !cfg_write;
   assign pos       = (state_ff == lppbp_pkg::S_INSTALL) ? used : p_ff;
   assign q_fidx    = FW'(fidx_ff);
   assign q_tbl     = tbl_ff;
   assign q_page    = page_ff;

   always_comb begin
      op       = lppbp_pkg::DOP_NONE;
      emit     = 1'b0;
      e_frame  = '0;
      e_hit    = 1'b0;
      e_load   = 1'b0;
      e_wb     = 1'b0;
      e_wbt    = '0;
      e_wbp    = '0;
      e_status = lppbp_pkg::STAT_OK;
      e_last   = 1'b1;
      unique case (state_ff)
         lppbp_pkg::S_IDLE: begin
            if (cfg_write) begin
               op = lppbp_pkg::DOP_CLEAR;
            end
         end
         lppbp_pkg::S_UNPIN: begin
            if (slot_free) begin
               emit    = 1'b1;
               e_frame = fidx_ff;
               if (fidx_ok) begin
                  op = lppbp_pkg::DOP_UNPIN;
               end
            end
         end
         lppbp_pkg::S_DSCAN: begin
            if (!(fidx_ok && fidx_in_use)) begin
               emit    = slot_free;
               e_frame = fidx_ff;
            end else if (m_frame && slot_free) begin
               op      = lppbp_pkg::DOP_DIRTY;
               emit    = 1'b1;
               e_frame = fidx_ff;
            end
         end
         lppbp_pkg::S_HSCAN: begin
            if (!scan_end && m_read && slot_free) begin
               op      = lppbp_pkg::DOP_HIT;
               emit    = 1'b1;
               e_frame = lppbp_pkg::FRAME_W'(rd_frame);
               e_hit   = 1'b1;
            end
         end
         lppbp_pkg::S_VSCAN: begin
            if (rd_pin_zero) begin
               op = lppbp_pkg::DOP_RELEASE;
            end else if (p_ff == '0) begin
               emit     = slot_free;
               e_status = lppbp_pkg::STAT_ALL_PINNED;
            end
         end
         lppbp_pkg::S_INSTALL: begin
            if (slot_free) begin
               op      = lppbp_pkg::DOP_INSTALL;
               emit    = 1'b1;
               e_frame = lppbp_pkg::FRAME_W'(rd_frame);
               e_load  = 1'b1;
               e_wb    = wb_ff;
               e_wbt   = wb_ff ? wbt_ff : '0;
               e_wbp   = wb_ff ? wbp_ff : '0;
            end
         end
         lppbp_pkg::S_CSCAN: begin
            if (scan_end) begin
               emit = slot_free;
            end else if (m_close && slot_free) begin
               emit    = 1'b1;
               e_frame = lppbp_pkg::FRAME_W'(rd_frame);
               if (!rd_pin_zero) begin
                  e_status = lppbp_pkg::STAT_TABLE_PINNED;
               end else begin
                  op     = lppbp_pkg::DOP_RELEASE;
                  e_last = 1'b0;
                  e_wb   = rd_dirty;
                  e_wbt  = rd_dirty ? rd_tbl : '0;
                  e_wbp  = rd_dirty ? rd_page : '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      unique case (state_ff)
         lppbp_pkg::S_IDLE: begin
            p_in = '0;
            if (req_acc) begin
               unique case (lppbp_pkg::cmd_type'(req.command))
                  lppbp_pkg::CMD_READ:  state_in = lppbp_pkg::S_HSCAN;
                  lppbp_pkg::CMD_UNPIN: state_in = lppbp_pkg::S_UNPIN;
                  lppbp_pkg::CMD_DIRTY: state_in = lppbp_pkg::S_DSCAN;
                  lppbp_pkg::CMD_CLOSE: state_in = lppbp_pkg::S_CSCAN;
                  default:              state_in = lppbp_pkg::S_IDLE;
               endcase
            end
         end
         lppbp_pkg::S_HSCAN: begin
            if (scan_end) begin
               if (used < nf) begin
                  state_in = lppbp_pkg::S_INSTALL;
               end else begin
                  state_in = lppbp_pkg::S_VSCAN;
                  p_in     = nf - CW'(1);
               end
            end else if (!m_read) begin
               p_in = p_ff + CW'(1);
            end
         end
         lppbp_pkg::S_VSCAN: begin
            if (rd_pin_zero) begin
               state_in = lppbp_pkg::S_INSTALL;
            end else if (p_ff != '0) begin
               p_in = p_ff - CW'(1);
            end
         end
         lppbp_pkg::S_DSCAN: begin
            if (fidx_ok && fidx_in_use && !m_frame) begin
               p_in = p_ff + CW'(1);
            end
         end
         lppbp_pkg::S_CSCAN: begin
            if (!scan_end && !m_close) begin
               p_in = p_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
      if (emit && e_last) begin
         state_in = lppbp_pkg::S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lppbp_pkg::S_IDLE;
         p_ff     <= '0;
         rv_ff    <= 1'b0;
         wb_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
         if (emit) begin
            rv_ff <= 1'b1;
         end else if (rsp.ready) begin
            rv_ff <= 1'b0;
         end
         if (req_acc) begin
            wb_ff <= 1'b0;
         end else if (state_ff == lppbp_pkg::S_VSCAN && rd_pin_zero) begin
            wb_ff <= rd_dirty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff  <= lppbp_pkg::cmd_type'(req.command);
         tbl_ff  <= TABLE_BITS'(req.table_num);
         page_ff <= req.page_number;
         fidx_ff <= req.frame_index;
      end
      if (state_ff == lppbp_pkg::S_VSCAN && rd_pin_zero) begin
         wbt_ff <= rd_tbl;
         wbp_ff <= rd_page;
      end
      if (emit) begin
         r_frame_ff  <= e_frame;
         r_hit_ff    <= e_hit;
         r_load_ff   <= e_load;
         r_wb_ff     <= e_wb;
         r_wbt_ff    <= lppbp_pkg::TABLE_W'(e_wbt);
         r_wbp_ff    <= e_wbp;
         r_status_ff <= e_status;
         r_last_ff   <= e_last;
      end
   end

   assign rsp.valid           = rv_ff;
   assign rsp.frame_index_res = r_frame_ff;
   assign rsp.hit             = r_hit_ff;
   assign rsp.load_request    = r_load_ff;
   assign rsp.writeback       = r_wb_ff;
   assign rsp.writeback_table = r_wbt_ff;
   assign rsp.writeback_page  = r_wbp_ff;
   assign rsp.status          = r_status_ff;
   assign rsp.last            = r_last_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset) used <= nf)
      else $error("used count above frame count");
   a_hscan_ptr: assert property (@(posedge clock) disable iff (reset)
      state_ff == lppbp_pkg::S_HSCAN |-> p_ff <= used)
      else $error("lookup pointer beyond used frames");
   a_busy: assert property (@(posedge clock) disable iff (reset) req_acc |=> !idle)
      else $error("accepted word left no work");
   a_slot: assert property (@(posedge clock) disable iff (reset) emit |-> slot_free)
      else $error("result overwrote a pending word");
   a_cmd: assert property (@(posedge clock) disable iff (reset)
      state_ff == lppbp_pkg::S_HSCAN |-> cmd_ff == lppbp_pkg::CMD_READ)
      else $error("lookup without read command");

endmodule

>>> rtl/lru_pinned_page_buffer_pool.sv
// Unpin needs no scan; read hit and mark dirty walk the recency list to the frame
//   (mark dirty of a free or unmanaged frame needs no scan); read miss scans the used
//   frames, then installs into a free frame or evicts the least recent unpinned one.
// Close: a word per matching frame plus a final word. One request at a time, the next
//   taken once idle after the last word; the shared compare walks the recency list one
//   entry per cycle, a held rsp stalling only the steps that issue a word.
// Reset or a frames_in_use write frees all frames, recency by index; reset sets 32 frames.
module lru_pinned_page_buffer_pool #(
   parameter int NUM_FRAMES = lppbp_pkg::NUM_FRAMES_DEF,
   parameter int TABLE_BITS = lppbp_pkg::TABLE_BITS_DEF,
   parameter int PIN_BITS   = lppbp_pkg::PIN_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   lppbp_req_if.sink    req,
   lppbp_rsp_if.source  rsp,
   lppbp_csr_if.sink    csr
);

   localparam int FW = $clog2(NUM_FRAMES);
   localparam int CW = $clog2(NUM_FRAMES + 1);

   logic [lppbp_pkg::CFG_W-1:0]     frames_ff;
   logic [CW-1:0]                   nf;
   logic                            idle, cfg_write;
   lppbp_pkg::dir_op_type           op;
   logic [CW-1:0]                   pos, used;
   logic [FW-1:0]                   q_fidx, rd_frame;
   logic [TABLE_BITS-1:0]           q_tbl, rd_tbl;
   logic [lppbp_pkg::PAGE_W-1:0]    q_page, rd_page;
   logic                            rd_pin_zero, rd_dirty, fidx_in_use;

   assign csr.ready = idle;
   assign cfg_write = csr.valid && csr.ready;

   always_comb begin
      if (frames_ff == '0) begin
         nf = CW'(1);
      end else if (32'(frames_ff) > NUM_FRAMES) begin
         nf = CW'(NUM_FRAMES);
      end else begin
         nf = CW'(frames_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= lppbp_pkg::CFG_RESET;
      end else if (cfg_write) begin
         frames_ff <= csr.frames_in_use;
      end
   end

   lppbp_seq #(
      .NUM_FRAMES(NUM_FRAMES),
      .TABLE_BITS(TABLE_BITS)
   ) u_seq (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .cfg_write(cfg_write), .nf(nf), .idle(idle),
      .op(op), .pos(pos), .q_fidx(q_fidx), .q_tbl(q_tbl), .q_page(q_page),
      .rd_frame(rd_frame), .rd_tbl(rd_tbl), .rd_page(rd_page),
      .rd_pin_zero(rd_pin_zero), .rd_dirty(rd_dirty),
      .fidx_in_use(fidx_in_use), .used(used)
   );

   lppbp_dir #(
      .NUM_FRAMES(NUM_FRAMES),
      .TABLE_BITS(TABLE_BITS),
      .PIN_BITS(PIN_BITS)
   ) u_dir (
      .clock(clock), .reset(reset),
      .op(op), .pos(pos), .fidx(q_fidx), .new_tbl(q_tbl), .ins_page(q_page),
      .rd_frame(rd_frame), .rd_tbl(rd_tbl), .rd_page(rd_page),
      .rd_pin_zero(rd_pin_zero), .rd_dirty(rd_dirty),
      .fidx_in_use(fidx_in_use), .used(used)
   );

endmodule
